FILE: src/btt_pkg.sv
// Shared constants, types and the sine table of the turtle interpreter.
package btt_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam int COORD_W = 24;
	localparam int SUM_W = COORD_W + 2;
	localparam int HEAD_W = 16;
	localparam int STEP_W = 16;
	localparam int TURN_W = 16;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int POS_RAM_W = 2 * COORD_W;

	localparam int ANG_W = 14;
	localparam int IDX_W = 7;
	localparam int FRAC_W = 7;
	localparam int DIFF_W = 9;
	localparam int NUM_W = 16;
	localparam int SIN_W = 15;
	localparam int MAG_W = 17;
	localparam int LANES = 2;

	localparam logic [HEAD_W-1:0] FULL_TURN = 16'd36000;
	localparam logic [HEAD_W-1:0] THREE_QUARTER = 16'd27000;
	localparam logic [HEAD_W-1:0] HALF_TURN = 16'd18000;
	localparam logic [HEAD_W-1:0] QUARTER_TURN = 16'd9000;

	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int RECIP_SHIFT = 19;
	localparam logic [NUM_W-1:0] INTERP_ROUND = 16'd50;
	localparam logic [IDX_W-1:0] LAST_DEG = 7'd90;
	localparam logic [ANG_W-1:0] DEG_SCALE = 14'd100;
	localparam logic [31:0] MOVE_ROUND = 32'd8192;
	localparam int MOVE_SHIFT = 14;

	localparam logic [7:0] SYM_FWD = 8'h46;
	localparam logic [7:0] SYM_PUSH = 8'h5B;
	localparam logic [7:0] SYM_POP = 8'h5D;
	localparam logic [7:0] SYM_LEFT = 8'h2B;
	localparam logic [7:0] SYM_RIGHT = 8'h2D;

	localparam logic [TURN_W-1:0] RST_TURN = 16'd2250;
	localparam logic [STEP_W-1:0] RST_STEP = 16'd1280;

	typedef enum logic [1:0] {
		FAULT_NONE = 2'd0,
		FAULT_POP_EMPTY = 2'd1,
		FAULT_PUSH_FULL = 2'd2
	} fault_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TURN = 3'd0,
		CFG_VERT = 3'd1,
		CFG_STEP = 3'd2,
		CFG_START_X = 3'd3,
		CFG_START_Y = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic is_f;
		logic push_ok;
		logic pop_ok;
		fault_t fault;
		logic ws;
		logic [STK_AW-1:0] addr;
	} ctrl_t;

	localparam logic [SIN_W-1:0] SINE_TAB [0:90] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
		15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
		15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
		15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
		15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
		15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
		15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
		15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
		15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
		15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
		15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
		15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
		15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
		15'd16384
	};

	// sine of a whole degree, 0..90, Q1.14
	function automatic logic [SIN_W-1:0] sine_deg(input logic [IDX_W-1:0] d);
		logic [SIN_W-1:0] v;
		if (d > LAST_DEG) begin
			v = SINE_TAB[90];
		end else begin
			v = SINE_TAB[d];
		end
		return v;
	endfunction

endpackage

FILE: src/btt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module btt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/btt_front.sv
// Front end: symbol decode, heading, stack count and the heading stack RAM.
module btt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [7:0]                    symbol,
	input  logic                          word_start,
	input  logic [btt_pkg::TURN_W-1:0]    turn_angle,
	input  logic                          start_vertical,
	output logic                          v_s1,
	output logic [btt_pkg::HEAD_W-1:0]    h_s1,
	output btt_pkg::ctrl_t                ctrl_s1
);

	logic [btt_pkg::HEAD_W-1:0] h_q;
	logic [btt_pkg::CNT_W-1:0]  cnt_q;
	logic                       pend_q;

	logic                       acc;
	logic [btt_pkg::HEAD_W-1:0] hrd;
	logic [btt_pkg::HEAD_W-1:0] h_base;
	logic [btt_pkg::HEAD_W-1:0] h_eff;
	logic [btt_pkg::HEAD_W-1:0] turn_red;
	logic [btt_pkg::HEAD_W:0]   plus_sum;
	logic [btt_pkg::HEAD_W-1:0] h_plus;
	logic [btt_pkg::HEAD_W-1:0] h_minus;
	logic [btt_pkg::HEAD_W-1:0] h_nxt;
	logic [btt_pkg::CNT_W-1:0]  cnt_eff;
	logic [btt_pkg::CNT_W-1:0]  cnt_m1;
	logic [btt_pkg::CNT_W-1:0]  cnt_nxt;
	btt_pkg::ctrl_t             ctrl;

	assign acc = in_valid & adv;

	always_comb begin
		h_base = pend_q ? hrd : h_q;
		if (word_start) begin
			h_eff = start_vertical ? btt_pkg::QUARTER_TURN : '0;
		end else begin
			h_eff = h_base;
		end
		turn_red = (turn_angle >= btt_pkg::FULL_TURN) ?
			turn_angle - btt_pkg::FULL_TURN : turn_angle;
		plus_sum = {1'b0, h_eff} + {1'b0, turn_red};
		if (plus_sum >= {1'b0, btt_pkg::FULL_TURN}) begin
			h_plus = btt_pkg::HEAD_W'(plus_sum - {1'b0, btt_pkg::FULL_TURN});
		end else begin
			h_plus = plus_sum[btt_pkg::HEAD_W-1:0];
		end
		if (h_eff >= turn_red) begin
			h_minus = h_eff - turn_red;
		end else begin
			h_minus = h_eff + (btt_pkg::FULL_TURN - turn_red);
		end

		cnt_eff = word_start ? '0 : cnt_q;
		cnt_m1 = cnt_eff - 1'b1;
		h_nxt = h_eff;
		cnt_nxt = cnt_eff;
		ctrl = '0;
		ctrl.fault = btt_pkg::FAULT_NONE;
		ctrl.ws = word_start;
		ctrl.addr = cnt_eff[btt_pkg::STK_AW-1:0];
		unique case (symbol)
			btt_pkg::SYM_FWD: begin
				ctrl.is_f = 1'b1;
			end
			btt_pkg::SYM_PUSH: begin
				if (cnt_eff == btt_pkg::CNT_W'(btt_pkg::STACK_DEPTH)) begin
					ctrl.fault = btt_pkg::FAULT_PUSH_FULL;
				end else begin
					ctrl.push_ok = 1'b1;
					cnt_nxt = cnt_eff + 1'b1;
				end
			end
			btt_pkg::SYM_POP: begin
				if (cnt_eff == '0) begin
					ctrl.fault = btt_pkg::FAULT_POP_EMPTY;
				end else begin
					ctrl.pop_ok = 1'b1;
					cnt_nxt = cnt_m1;
					ctrl.addr = cnt_m1[btt_pkg::STK_AW-1:0];
				end
			end
			btt_pkg::SYM_LEFT: begin
				h_nxt = h_plus;
			end
			btt_pkg::SYM_RIGHT: begin
				h_nxt = h_minus;
			end
			default: ;
		endcase
	end

	// heading saved on push; on a pop it is read out and used by the next accepted symbol
	btt_ram #(
		.WIDTH(btt_pkg::HEAD_W),
		.DEPTH(btt_pkg::STACK_DEPTH)
	) u_head_ram (
		.clk  (clk),
		.we   (acc & ctrl.push_ok),
		.waddr(ctrl.addr),
		.wdata(h_eff),
		.re   (acc & ctrl.pop_ok),
		.raddr(ctrl.addr),
		.rdata(hrd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= btt_pkg::QUARTER_TURN;
			cnt_q <= '0;
			pend_q <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= in_valid;
			end
			if (acc) begin
				h_q <= h_nxt;
				cnt_q <= cnt_nxt;
				pend_q <= ctrl.pop_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			h_s1 <= h_eff;
			ctrl_s1 <= ctrl;
		end
	end

endmodule

FILE: src/btt_trig.sv
// Cosine/sine lanes: quadrant fold, table interpolation and scaling by step length.
module btt_trig (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          v_s1,
	input  logic [btt_pkg::HEAD_W-1:0]    h_s1,
	input  btt_pkg::ctrl_t                ctrl_s1,
	input  logic [btt_pkg::STEP_W-1:0]    step_length,
	output logic                          v_s7,
	output btt_pkg::ctrl_t                ctrl_s7,
	output logic [btt_pkg::MAG_W-1:0]     mag_s7 [btt_pkg::LANES],
	output logic                          neg_s7 [btt_pkg::LANES]
);

	logic v_s2, v_s3, v_s4, v_s5, v_s6;
	btt_pkg::ctrl_t ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6;

	logic [btt_pkg::ANG_W-1:0]  a_s2   [btt_pkg::LANES];
	logic                       neg_s2 [btt_pkg::LANES];
	logic [btt_pkg::ANG_W-1:0]  a_s3   [btt_pkg::LANES];
	logic [btt_pkg::IDX_W-1:0]  i_s3   [btt_pkg::LANES];
	logic                       neg_s3 [btt_pkg::LANES];
	logic [btt_pkg::FRAC_W-1:0] f_s4   [btt_pkg::LANES];
	logic [btt_pkg::SIN_W-1:0]  lo_s4  [btt_pkg::LANES];
	logic [btt_pkg::DIFF_W-1:0] diff_s4 [btt_pkg::LANES];
	logic                       neg_s4 [btt_pkg::LANES];
	logic [btt_pkg::NUM_W-1:0]  n_s5   [btt_pkg::LANES];
	logic [btt_pkg::SIN_W-1:0]  lo_s5  [btt_pkg::LANES];
	logic                       neg_s5 [btt_pkg::LANES];
	logic [btt_pkg::SIN_W-1:0]  s_s6   [btt_pkg::LANES];
	logic                       neg_s6 [btt_pkg::LANES];

	logic [btt_pkg::HEAD_W:0]   hc_sum;
	logic [btt_pkg::HEAD_W-1:0] hh     [btt_pkg::LANES];
	logic [btt_pkg::ANG_W-1:0]  a_c    [btt_pkg::LANES];
	logic                       neg_c  [btt_pkg::LANES];
	logic [26:0]                ip     [btt_pkg::LANES];
	logic [btt_pkg::ANG_W-1:0]  fw     [btt_pkg::LANES];
	logic [btt_pkg::SIN_W-1:0]  lo_c   [btt_pkg::LANES];
	logic [btt_pkg::SIN_W-1:0]  hi_c   [btt_pkg::LANES];
	logic [btt_pkg::NUM_W-1:0]  n_c    [btt_pkg::LANES];
	logic [28:0]                qp     [btt_pkg::LANES];
	logic [btt_pkg::SIN_W-1:0]  s_c    [btt_pkg::LANES];
	logic [31:0]                pr     [btt_pkg::LANES];

	// lane 0 is cosine (heading plus a quarter turn), lane 1 is sine
	always_comb begin
		hc_sum = {1'b0, h_s1} + {1'b0, btt_pkg::QUARTER_TURN};
		if (hc_sum >= {1'b0, btt_pkg::FULL_TURN}) begin
			hh[0] = btt_pkg::HEAD_W'(hc_sum - {1'b0, btt_pkg::FULL_TURN});
		end else begin
			hh[0] = hc_sum[btt_pkg::HEAD_W-1:0];
		end
		hh[1] = h_s1;
		for (int l = 0; l < btt_pkg::LANES; l++) begin
			priority if (hh[l] < btt_pkg::QUARTER_TURN) begin
				a_c[l] = hh[l][btt_pkg::ANG_W-1:0];
				neg_c[l] = 1'b0;
			end else if (hh[l] < btt_pkg::HALF_TURN) begin
				a_c[l] = btt_pkg::ANG_W'(btt_pkg::HALF_TURN - hh[l]);
				neg_c[l] = 1'b0;
			end else if (hh[l] < btt_pkg::THREE_QUARTER) begin
				a_c[l] = btt_pkg::ANG_W'(hh[l] - btt_pkg::HALF_TURN);
				neg_c[l] = 1'b1;
			end else begin
				a_c[l] = btt_pkg::ANG_W'(btt_pkg::FULL_TURN - hh[l]);
				neg_c[l] = 1'b1;
			end
			// whole degrees: a / 100 by reciprocal, exact below 43690
			ip[l] = 27'(a_s2[l]) * 27'(btt_pkg::RECIP_100);
			fw[l] = a_s3[l] - 14'(i_s3[l]) * btt_pkg::DEG_SCALE;
			lo_c[l] = btt_pkg::sine_deg(i_s3[l]);
			hi_c[l] = (i_s3[l] < btt_pkg::LAST_DEG) ?
				btt_pkg::sine_deg(i_s3[l] + 1'b1) : lo_c[l];
			n_c[l] = 16'(diff_s4[l]) * 16'(f_s4[l]) + btt_pkg::INTERP_ROUND;
			qp[l] = 29'(n_s5[l]) * 29'(btt_pkg::RECIP_100);
			s_c[l] = lo_s5[l] + 15'(qp[l][btt_pkg::RECIP_SHIFT +: btt_pkg::DIFF_W]);
			pr[l] = 32'(step_length) * 32'(s_s6[l]) + btt_pkg::MOVE_ROUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
			ctrl_s6 <= ctrl_s5;
			ctrl_s7 <= ctrl_s6;
			for (int l = 0; l < btt_pkg::LANES; l++) begin
				a_s2[l] <= a_c[l];
				neg_s2[l] <= neg_c[l];
				a_s3[l] <= a_s2[l];
				i_s3[l] <= ip[l][btt_pkg::RECIP_SHIFT +: btt_pkg::IDX_W];
				neg_s3[l] <= neg_s2[l];
				f_s4[l] <= fw[l][btt_pkg::FRAC_W-1:0];
				lo_s4[l] <= lo_c[l];
				diff_s4[l] <= btt_pkg::DIFF_W'(hi_c[l] - lo_c[l]);
				neg_s4[l] <= neg_s3[l];
				n_s5[l] <= n_c[l];
				lo_s5[l] <= lo_s4[l];
				neg_s5[l] <= neg_s4[l];
				s_s6[l] <= s_c[l];
				neg_s6[l] <= neg_s5[l];
				mag_s7[l] <= pr[l][btt_pkg::MOVE_SHIFT +: btt_pkg::MAG_W];
				neg_s7[l] <= neg_s6[l];
			end
		end
	end

endmodule

FILE: src/btt_back.sv
// Back end: position update with clamping, position stack RAM and result register.
module btt_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 v_s7,
	input  btt_pkg::ctrl_t                       ctrl_s7,
	input  logic [btt_pkg::MAG_W-1:0]            mag_s7 [btt_pkg::LANES],
	input  logic                                 neg_s7 [btt_pkg::LANES],
	input  logic signed [btt_pkg::COORD_W-1:0]   start_x,
	input  logic signed [btt_pkg::COORD_W-1:0]   start_y,
	output logic                                 out_valid,
	output logic                                 draw,
	output logic signed [btt_pkg::COORD_W-1:0]   seg_x0,
	output logic signed [btt_pkg::COORD_W-1:0]   seg_y0,
	output logic signed [btt_pkg::COORD_W-1:0]   seg_x1,
	output logic signed [btt_pkg::COORD_W-1:0]   seg_y1,
	output logic [1:0]                           stack_fault,
	output logic                                 saturated
);

	logic                                 v_s8;
	btt_pkg::ctrl_t                       ctrl_s8;
	logic [btt_pkg::MAG_W-1:0]            mag_s8 [btt_pkg::LANES];
	logic                                 neg_s8 [btt_pkg::LANES];
	logic                                 fwd_s8;
	logic signed [btt_pkg::COORD_W-1:0]   pos_q  [btt_pkg::LANES];

	logic                                 re;
	logic                                 we;
	logic [btt_pkg::POS_RAM_W-1:0]        prd;
	logic signed [btt_pkg::COORD_W-1:0]   p_eff  [btt_pkg::LANES];
	logic signed [btt_pkg::MAG_W:0]       dm     [btt_pkg::LANES];
	logic signed [btt_pkg::MAG_W:0]       dd     [btt_pkg::LANES];
	logic signed [btt_pkg::SUM_W-1:0]     sum    [btt_pkg::LANES];
	logic signed [btt_pkg::COORD_W-1:0]   p_end  [btt_pkg::LANES];
	logic                                 clip   [btt_pkg::LANES];
	logic signed [btt_pkg::COORD_W-1:0]   p_pop  [btt_pkg::LANES];

	// read from the s7 control so the saved position lands with the pop in s8
	assign re = adv & v_s7 & ctrl_s7.pop_ok;
	assign we = adv & v_s8 & ctrl_s8.push_ok;

	btt_ram #(
		.WIDTH(btt_pkg::POS_RAM_W),
		.DEPTH(btt_pkg::STACK_DEPTH)
	) u_pos_ram (
		.clk  (clk),
		.we   (we),
		.waddr(ctrl_s8.addr),
		.wdata({p_eff[0], p_eff[1]}),
		.re   (re),
		.raddr(ctrl_s7.addr),
		.rdata(prd)
	);

	always_comb begin
		p_eff[0] = ctrl_s8.ws ? start_x : pos_q[0];
		p_eff[1] = ctrl_s8.ws ? start_y : pos_q[1];
		p_pop[0] = fwd_s8 ? pos_q[0] : prd[btt_pkg::COORD_W +: btt_pkg::COORD_W];
		p_pop[1] = fwd_s8 ? pos_q[1] : prd[0 +: btt_pkg::COORD_W];
		for (int l = 0; l < btt_pkg::LANES; l++) begin
			dm[l] = signed'({1'b0, mag_s8[l]});
			dd[l] = neg_s8[l] ? -dm[l] : dm[l];
			sum[l] = btt_pkg::SUM_W'(p_eff[l]) + btt_pkg::SUM_W'(dd[l]);
			clip[l] = (sum[l][btt_pkg::SUM_W-1:btt_pkg::COORD_W-1] != '0) &&
				(sum[l][btt_pkg::SUM_W-1:btt_pkg::COORD_W-1] != '1);
			if (clip[l]) begin
				p_end[l] = sum[l][btt_pkg::SUM_W-1] ?
					{1'b1, {(btt_pkg::COORD_W-1){1'b0}}} :
					{1'b0, {(btt_pkg::COORD_W-1){1'b1}}};
			end else begin
				p_end[l] = sum[l][btt_pkg::COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			out_valid <= 1'b0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
		end else if (adv) begin
			v_s8 <= v_s7;
			out_valid <= v_s8;
			if (v_s8) begin
				priority if (ctrl_s8.is_f) begin
					pos_q[0] <= p_end[0];
					pos_q[1] <= p_end[1];
				end else if (ctrl_s8.pop_ok) begin
					pos_q[0] <= p_pop[0];
					pos_q[1] <= p_pop[1];
				end else begin
					pos_q[0] <= p_eff[0];
					pos_q[1] <= p_eff[1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s8 <= ctrl_s7;
			fwd_s8 <= re & we & (ctrl_s7.addr == ctrl_s8.addr);
			for (int l = 0; l < btt_pkg::LANES; l++) begin
				mag_s8[l] <= mag_s7[l];
				neg_s8[l] <= neg_s7[l];
			end
			if (v_s8) begin
				draw <= ctrl_s8.is_f;
				stack_fault <= ctrl_s8.fault;
				saturated <= ctrl_s8.is_f & (clip[0] | clip[1]);
				seg_x0 <= ctrl_s8.is_f ? p_eff[0] : '0;
				seg_y0 <= ctrl_s8.is_f ? p_eff[1] : '0;
				seg_x1 <= ctrl_s8.is_f ? p_end[0] : '0;
				seg_y1 <= ctrl_s8.is_f ? p_end[1] : '0;
			end
		end
	end

endmodule

FILE: src/bracketed_turtle_interpreter.sv
// Bracketed L-system turtle interpreter: top level with configuration registers.
// After its symbol is accepted, a result passes the front decode, six stages of
// trig lanes, the position stage and the result register.
// Throughput: one symbol per cycle, stalled only while the result register waits.
// Reset clears the configuration to defaults, puts the turtle at the start position
// heading 90 degrees and empties the stack; the stack RAMs are not cleared.
module bracketed_turtle_interpreter (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [7:0]                             symbol,
	input  logic                                   word_start,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   draw,
	output logic signed [btt_pkg::COORD_W-1:0]     seg_x0,
	output logic signed [btt_pkg::COORD_W-1:0]     seg_y0,
	output logic signed [btt_pkg::COORD_W-1:0]     seg_x1,
	output logic signed [btt_pkg::COORD_W-1:0]     seg_y1,
	output logic [1:0]                             stack_fault,
	output logic                                   saturated,
	input  logic                                   cfg_we,
	input  logic [btt_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [btt_pkg::CFG_W-1:0]              cfg_data
);

	logic [btt_pkg::TURN_W-1:0]          turn_q;
	logic                                vert_q;
	logic [btt_pkg::STEP_W-1:0]          step_q;
	logic signed [btt_pkg::COORD_W-1:0]  sx_q;
	logic signed [btt_pkg::COORD_W-1:0]  sy_q;

	logic                                adv;
	logic                                v_s1;
	logic [btt_pkg::HEAD_W-1:0]          h_s1;
	btt_pkg::ctrl_t                      ctrl_s1;
	logic                                v_s7;
	btt_pkg::ctrl_t                      ctrl_s7;
	logic [btt_pkg::MAG_W-1:0]           mag_s7 [btt_pkg::LANES];
	logic                                neg_s7 [btt_pkg::LANES];

	assign adv = ~out_valid | out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_q <= btt_pkg::RST_TURN;
			vert_q <= 1'b1;
			step_q <= btt_pkg::RST_STEP;
			sx_q <= '0;
			sy_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				btt_pkg::CFG_TURN:    turn_q <= cfg_data[btt_pkg::TURN_W-1:0];
				btt_pkg::CFG_VERT:    vert_q <= cfg_data[0];
				btt_pkg::CFG_STEP:    step_q <= cfg_data[btt_pkg::STEP_W-1:0];
				btt_pkg::CFG_START_X: sx_q <= cfg_data;
				btt_pkg::CFG_START_Y: sy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	btt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.symbol        (symbol),
		.word_start    (word_start),
		.turn_angle    (turn_q),
		.start_vertical(vert_q),
		.v_s1          (v_s1),
		.h_s1          (h_s1),
		.ctrl_s1       (ctrl_s1)
	);

	btt_trig u_trig (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.v_s1       (v_s1),
		.h_s1       (h_s1),
		.ctrl_s1    (ctrl_s1),
		.step_length(step_q),
		.v_s7       (v_s7),
		.ctrl_s7    (ctrl_s7),
		.mag_s7     (mag_s7),
		.neg_s7     (neg_s7)
	);

	btt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.v_s7       (v_s7),
		.ctrl_s7    (ctrl_s7),
		.mag_s7     (mag_s7),
		.neg_s7     (neg_s7),
		.start_x    (sx_q),
		.start_y    (sy_q),
		.out_valid  (out_valid),
		.draw       (draw),
		.seg_x0     (seg_x0),
		.seg_y0     (seg_y0),
		.seg_x1     (seg_x1),
		.seg_y1     (seg_y1),
		.stack_fault(stack_fault),
		.saturated  (saturated)
	);

	a_draw_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && draw |-> stack_fault == btt_pkg::FAULT_NONE)
		else $error("segment item carries a stack fault");

	a_sat_on_draw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> draw)
		else $error("clamp flagged on an item with no segment");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !draw |-> seg_x0 == '0 && seg_y0 == '0 &&
			seg_x1 == '0 && seg_y1 == '0)
		else $error("non-drawing item has segment coordinates");

endmodule
